FILE: sv/btq_pkg.sv
// Shared types, constants and register codes for the bitmap text quad layout block.
`default_nettype none

package btq_pkg;

  // Cursor bounds and widths
  localparam int MAX_COLUMNS = 255;
  localparam int MAX_ROWS    = 255;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W       = $clog2(MAX_ROWS + 1);
  // Room for cursor plus a tab advance of up to 31 columns
  localparam int COL_SUM_W   = COL_W + 6;
  localparam int ROW_SUM_W   = ROW_W + 1;

  // Shared multiplier: operands are wide enough for a cursor or a 12-bit cell size
  localparam int CELL_W      = 12;
  localparam int MUL_W       = (COL_W > CELL_W) ? ((COL_W > ROW_W) ? COL_W : ROW_W) :
                               ((ROW_W > CELL_W) ? ROW_W : CELL_W);
  localparam int PROD_W      = 2 * MUL_W;

  // Field widths
  localparam int CODE_W      = 8;
  localparam int GLYPH_W     = 7;
  localparam int SCALE_W     = 5;
  localparam int TAB_W       = 5;
  localparam int COLOR_W     = 32;
  localparam int SCREEN_W    = 19;
  localparam int TEX_W       = 11;
  localparam int CORNER_W    = 2;
  localparam logic [SCREEN_W-1:0] SCREEN_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_LOADED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd5;

  // Reset values of the registers
  localparam logic [GLYPH_W-1:0] RST_GLYPH_WIDTH  = 7'd8;
  localparam logic [GLYPH_W-1:0] RST_GLYPH_HEIGHT = 7'd8;
  localparam logic [SCALE_W-1:0] RST_ZOOM         = 5'd1;
  localparam logic [TAB_W-1:0]   RST_TAB_WIDTH    = 5'd4;
  localparam logic [COLOR_W-1:0] RST_FILL_COLOR   = 32'hFFFF_FFFF;

  // Character codes with cursor-only meaning
  localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NL    = 8'd10;
  localparam logic [CODE_W-1:0] CODE_VT    = 8'd11;
  localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

  // Corner codes
  localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic               font_loaded;
    logic [GLYPH_W-1:0] glyph_width;
    logic [GLYPH_W-1:0] glyph_height;
    logic [SCALE_W-1:0] zoom;
    logic [TAB_W-1:0]   tab_width;
    logic [COLOR_W-1:0] fill_color;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CW,
    ST_CH,
    ST_X,
    ST_Y,
    ST_U,
    ST_V,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bitmap_text_quad_layout_top.sv
// Top level: configuration registers, sequencer and shared multiplier.
// A printable character with a font loaded is accepted only in IDLE and then runs
// six products on the one shared multiplier (states CW, CH, X, Y, U, V, then FIN),
// then 4 corner beats, one per cycle while out_ready allows, from the output register.
// Whitespace, or any character with no font loaded, only moves the cursor in IDLE.
// Synchronous reset clears the cursor, the sequencer and the registers to their defaults.
`default_nettype none

module bitmap_text_quad_layout_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [btq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [btq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [btq_pkg::CODE_W-1:0]       char_code,
  input  wire logic                             string_start,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [btq_pkg::CORNER_W-1:0]     corner,
  output logic      [btq_pkg::SCREEN_W-1:0]     screen_x,
  output logic      [btq_pkg::SCREEN_W-1:0]     screen_y,
  output logic      [btq_pkg::TEX_W-1:0]        tex_u,
  output logic      [btq_pkg::TEX_W-1:0]        tex_v,
  output logic      [btq_pkg::COLOR_W-1:0]      vertex_color,
  output logic                                  quad_last
);

  btq_pkg::cfg_t               cfg;
  logic [btq_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [btq_pkg::PROD_W-1:0]  prod;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_loaded  <= 1'b0;
      cfg.glyph_width  <= btq_pkg::RST_GLYPH_WIDTH;
      cfg.glyph_height <= btq_pkg::RST_GLYPH_HEIGHT;
      cfg.zoom         <= btq_pkg::RST_ZOOM;
      cfg.tab_width    <= btq_pkg::RST_TAB_WIDTH;
      cfg.fill_color   <= btq_pkg::RST_FILL_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        btq_pkg::REG_FONT_LOADED:  cfg.font_loaded  <= cfg_data[0];
        btq_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[btq_pkg::GLYPH_W-1:0];
        btq_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[btq_pkg::GLYPH_W-1:0];
        btq_pkg::REG_ZOOM:         cfg.zoom         <= cfg_data[btq_pkg::SCALE_W-1:0];
        btq_pkg::REG_TAB_WIDTH:    cfg.tab_width    <= cfg_data[btq_pkg::TAB_W-1:0];
        btq_pkg::REG_FILL_COLOR:   cfg.fill_color   <= cfg_data[btq_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  btq_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .string_start (string_start),
    .mul_a        (mul_a),
    .mul_b        (mul_b),
    .prod         (prod),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .corner       (corner),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .vertex_color (vertex_color),
    .quad_last    (quad_last)
  );

  btq_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

endmodule

`default_nettype wire

FILE: sv/btq_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module btq_mul (
  input  wire logic                       clk,
  input  wire logic [btq_pkg::MUL_W-1:0]  mul_a,
  input  wire logic [btq_pkg::MUL_W-1:0]  mul_b,
  output logic      [btq_pkg::PROD_W-1:0] prod
);

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= btq_pkg::PROD_W'(mul_a) * btq_pkg::PROD_W'(mul_b);
  end

endmodule

`default_nettype wire

FILE: sv/btq_seq.sv
// Sequencer: cursor tracking, multiplier scheduling and corner output register.
`default_nettype none

module btq_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire btq_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [btq_pkg::CODE_W-1:0]   char_code,
  input  wire logic                         string_start,
  output logic      [btq_pkg::MUL_W-1:0]    mul_a,
  output logic      [btq_pkg::MUL_W-1:0]    mul_b,
  input  wire logic [btq_pkg::PROD_W-1:0]   prod,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [btq_pkg::CORNER_W-1:0] corner,
  output logic      [btq_pkg::SCREEN_W-1:0] screen_x,
  output logic      [btq_pkg::SCREEN_W-1:0] screen_y,
  output logic      [btq_pkg::TEX_W-1:0]    tex_u,
  output logic      [btq_pkg::TEX_W-1:0]    tex_v,
  output logic      [btq_pkg::COLOR_W-1:0]  vertex_color,
  output logic                              quad_last
);

  btq_pkg::state_t state, state_next;

  logic [btq_pkg::COL_W-1:0]     col, col_next, col_base;
  logic [btq_pkg::ROW_W-1:0]     row, row_next, row_base;
  logic [btq_pkg::COL_SUM_W-1:0] col_sum;
  logic [btq_pkg::ROW_SUM_W-1:0] row_sum;
  logic [btq_pkg::TAB_W-1:0]     col_step;
  logic                          is_print;
  logic                          accept;
  logic                          load_out;

  // Latched operands of the character in flight
  logic [btq_pkg::COL_W-1:0]  op_col;
  logic [btq_pkg::ROW_W-1:0]  op_row;
  logic [btq_pkg::CODE_W-1:0] op_code;

  // Products captured from the multiplier
  logic [btq_pkg::CELL_W-1:0] cw, ch;
  logic [btq_pkg::PROD_W-1:0] x1, y1;
  logic [btq_pkg::TEX_W-1:0]  u1, v1;

  logic [btq_pkg::CORNER_W-1:0] corner_cnt;
  logic                         right, bottom;
  logic [btq_pkg::PROD_W:0]     x_sum, y_sum;
  logic [btq_pkg::SCREEN_W-1:0] x_sat, y_sat;
  logic [btq_pkg::TEX_W-1:0]    u_val, v_val;

  // Character class
  always_comb begin
    is_print = !((char_code == btq_pkg::CODE_NL) || (char_code == btq_pkg::CODE_TAB) ||
                 ((char_code >= btq_pkg::CODE_VT) && (char_code <= btq_pkg::CODE_CR)) ||
                 (char_code == btq_pkg::CODE_SPACE));
  end

  // Cursor update with saturation
  always_comb begin
    col_base = string_start ? '0 : col;
    row_base = string_start ? '0 : row;
    col_step = (char_code == btq_pkg::CODE_TAB) ? cfg.tab_width : btq_pkg::TAB_W'(1);
    col_sum  = btq_pkg::COL_SUM_W'(col_base) + btq_pkg::COL_SUM_W'(col_step);
    row_sum  = btq_pkg::ROW_SUM_W'(row_base) + btq_pkg::ROW_SUM_W'(1);
    if (char_code == btq_pkg::CODE_NL) begin
      col_next = '0;
      row_next = (row_sum > btq_pkg::ROW_SUM_W'(btq_pkg::MAX_ROWS)) ?
                 btq_pkg::ROW_W'(btq_pkg::MAX_ROWS) : row_sum[btq_pkg::ROW_W-1:0];
    end else begin
      col_next = (col_sum > btq_pkg::COL_SUM_W'(btq_pkg::MAX_COLUMNS)) ?
                 btq_pkg::COL_W'(btq_pkg::MAX_COLUMNS) : col_sum[btq_pkg::COL_W-1:0];
      row_next = row_base;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      btq_pkg::ST_IDLE: begin
        if (in_valid && is_print && cfg.font_loaded) state_next = btq_pkg::ST_CW;
      end
      btq_pkg::ST_CW:  state_next = btq_pkg::ST_CH;
      btq_pkg::ST_CH:  state_next = btq_pkg::ST_X;
      btq_pkg::ST_X:   state_next = btq_pkg::ST_Y;
      btq_pkg::ST_Y:   state_next = btq_pkg::ST_U;
      btq_pkg::ST_U:   state_next = btq_pkg::ST_V;
      btq_pkg::ST_V:   state_next = btq_pkg::ST_FIN;
      btq_pkg::ST_FIN: state_next = btq_pkg::ST_EMIT;
      btq_pkg::ST_EMIT: begin
        if (load_out && (corner_cnt == btq_pkg::CORNER_BL)) state_next = btq_pkg::ST_IDLE;
      end
      default: state_next = btq_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and multiplier operands
  always_comb begin
    in_ready = (state == btq_pkg::ST_IDLE);
    load_out = (state == btq_pkg::ST_EMIT) && (!out_valid || out_ready);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      btq_pkg::ST_CW: begin
        mul_a = btq_pkg::MUL_W'(cfg.glyph_width);
        mul_b = btq_pkg::MUL_W'(cfg.zoom);
      end
      btq_pkg::ST_CH: begin
        mul_a = btq_pkg::MUL_W'(cfg.glyph_height);
        mul_b = btq_pkg::MUL_W'(cfg.zoom);
      end
      btq_pkg::ST_X: begin
        mul_a = btq_pkg::MUL_W'(op_col);
        mul_b = btq_pkg::MUL_W'(cw);
      end
      btq_pkg::ST_Y: begin
        mul_a = btq_pkg::MUL_W'(op_row);
        mul_b = btq_pkg::MUL_W'(ch);
      end
      btq_pkg::ST_U: begin
        mul_a = btq_pkg::MUL_W'(op_code[3:0]);
        mul_b = btq_pkg::MUL_W'(cfg.glyph_width);
      end
      btq_pkg::ST_V: begin
        mul_a = btq_pkg::MUL_W'(op_code[7:4]);
        mul_b = btq_pkg::MUL_W'(cfg.glyph_height);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= btq_pkg::ST_IDLE;
      col        <= '0;
      row        <= '0;
      corner_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      if (state == btq_pkg::ST_FIN) begin
        corner_cnt <= '0;
      end else if (load_out) begin
        corner_cnt <= corner_cnt + btq_pkg::CORNER_W'(1);
      end
    end
  end

  // Operand latch and product capture; each state stores the product issued before it
  always_ff @(posedge clk) begin
    if (accept) begin
      op_col  <= col_base;
      op_row  <= row_base;
      op_code <= char_code;
    end
    case (state)
      btq_pkg::ST_CH:  cw <= prod[btq_pkg::CELL_W-1:0];
      btq_pkg::ST_X:   ch <= prod[btq_pkg::CELL_W-1:0];
      btq_pkg::ST_Y:   x1 <= prod;
      btq_pkg::ST_U:   y1 <= prod;
      btq_pkg::ST_V:   u1 <= prod[btq_pkg::TEX_W-1:0];
      btq_pkg::ST_FIN: v1 <= prod[btq_pkg::TEX_W-1:0];
      default: ;
    endcase
  end

  // Corner values: offset right/bottom edges, saturate screen coordinates
  always_comb begin
    right  = (corner_cnt == btq_pkg::CORNER_TR) || (corner_cnt == btq_pkg::CORNER_BR);
    bottom = corner_cnt[1];
    x_sum  = (btq_pkg::PROD_W+1)'(x1) + (right  ? (btq_pkg::PROD_W+1)'(cw) : '0);
    y_sum  = (btq_pkg::PROD_W+1)'(y1) + (bottom ? (btq_pkg::PROD_W+1)'(ch) : '0);
    x_sat  = (x_sum > (btq_pkg::PROD_W+1)'(btq_pkg::SCREEN_MAX)) ?
             btq_pkg::SCREEN_MAX : x_sum[btq_pkg::SCREEN_W-1:0];
    y_sat  = (y_sum > (btq_pkg::PROD_W+1)'(btq_pkg::SCREEN_MAX)) ?
             btq_pkg::SCREEN_MAX : y_sum[btq_pkg::SCREEN_W-1:0];
    u_val  = u1 + (right  ? btq_pkg::TEX_W'(cfg.glyph_width)  : '0);
    v_val  = v1 + (bottom ? btq_pkg::TEX_W'(cfg.glyph_height) : '0);
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      corner       <= corner_cnt;
      screen_x     <= x_sat;
      screen_y     <= y_sat;
      tex_u        <= u_val;
      tex_v        <= v_val;
      vertex_color <= cfg.fill_color;
      quad_last    <= (corner_cnt == btq_pkg::CORNER_BL);
    end
  end

endmodule

`default_nettype wire
